@@ hw/rtl/ipv4_address_rewrite_checksum_macros.svh @@
// Assertion macros used by the checker file.
`ifndef IPV4_ADDRESS_REWRITE_CHECKSUM_MACROS_SVH
`define IPV4_ADDRESS_REWRITE_CHECKSUM_MACROS_SVH

// General property, sampled on clk, off while rst_n is low.
`define IARC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal is stable in the cycle after cond.
`define IARC_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
    else $error(msg);

`endif

@@ hw/rtl/ipv4arc_pkg.sv @@
// Shared types and constants for the IPv4 address rewrite block.
package ipv4arc_pkg;

  localparam int HDR_LEN   = 20;
  localparam int POS_W     = 5;
  localparam int ADDR_W    = 32;
  localparam int SUM_W     = 20;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;
  localparam int CFG_IDX_W = 1;

  localparam int SRC_AT  = 12;
  localparam int DST_AT  = 16;
  localparam int CSUM_AT = 10;

  localparam logic [POS_W-1:0] POS_BODY    = POS_W'(HDR_LEN);
  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(HDR_LEN - 1);
  localparam logic [POS_W-1:0] POS_SUM_END = POS_W'(CSUM_AT);
  localparam logic [POS_W-1:0] POS_CSUM_HI = POS_W'(CSUM_AT);
  localparam logic [POS_W-1:0] POS_CSUM_LO = POS_W'(CSUM_AT + 1);

  localparam logic [CFG_IDX_W-1:0] REG_LOCAL  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAPPED = CFG_IDX_W'(1);

  typedef enum logic [0:0] {
    CMD_BODY = 1'b0,
    CMD_HDR  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef logic [HDR_LEN-1:0][7:0] hdr_t;

  typedef struct packed {
    hdr_t        bytes;
    logic [15:0] csum;
  } hdr_view_t;

endpackage

@@ hw/rtl/ipv4arc_front.sv @@
// Front end: header capture, address match and rewrite, checksum, command issue.
module ipv4arc_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [ipv4arc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ipv4arc_pkg::ADDR_W-1:0]  cfg_wdata,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      in_byte_in,
  input  logic                            in_packet_end_in,
  output logic                            q_push,
  output ipv4arc_pkg::cmd_t               q_wdata,
  input  logic                            q_full,
  input  logic                            hdr_done,
  output ipv4arc_pkg::hdr_view_t          hdr_view
);
  import ipv4arc_pkg::*;

  typedef enum logic [3:0] {
    ST_RUN  = 4'b0001,
    ST_SRC  = 4'b0010,
    ST_DST  = 4'b0100,
    ST_PUSH = 4'b1000
  } fe_state_t;

  fe_state_t          state_r, state_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               keep_r, keep_nxt;
  logic               lock_r, lock_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  hdr_t               store_r, store_nxt;
  logic               hend_r, hend_nxt;
  logic [15:0]        csum_r, csum_nxt;
  logic [ADDR_W-1:0]  local_r, mapped_r;

  logic               accept;
  logic               dst_match, src_match;
  logic [16:0]        fold1, fold2;

  assign full   = (state_r != ST_RUN) || q_full || ((pos_r < POS_BODY) && lock_r);
  assign accept = push && !full;

  assign dst_match = ({store_r[DST_AT], store_r[DST_AT+1], store_r[DST_AT+2], in_byte_in}
                      == mapped_r);
  assign src_match = ({store_r[SRC_AT], store_r[SRC_AT+1], store_r[SRC_AT+2],
                       store_r[SRC_AT+3]} == local_r);

  // end-around carry fold, twice
  assign fold1 = {1'b0, sum_r[15:0]} + 17'(sum_r[SUM_W-1:16]);
  assign fold2 = fold1 + 17'(fold1[16]);

  assign hdr_view.bytes = store_r;
  assign hdr_view.csum  = csum_r;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    keep_nxt  = keep_r;
    lock_nxt  = lock_r;
    sum_nxt   = sum_r;
    store_nxt = store_r;
    hend_nxt  = hend_r;
    csum_nxt  = csum_r;
    q_push    = 1'b0;
    q_wdata   = '{kind: CMD_BODY, data: in_byte_in, last: in_packet_end_in};
    if (hdr_done) begin
      lock_nxt = 1'b0;
    end
    case (state_r)
      ST_RUN: begin
        if (accept) begin
          if (pos_r < POS_BODY) begin
            store_nxt[pos_r] = in_byte_in;
            if (pos_r == '0) begin
              sum_nxt = SUM_W'({in_byte_in, 8'h00});
            end else if (pos_r < POS_SUM_END) begin
              sum_nxt = sum_r + (pos_r[0] ? SUM_W'(in_byte_in) : SUM_W'({in_byte_in, 8'h00}));
            end
            if (pos_r == POS_LAST) begin
              hend_nxt = in_packet_end_in;
              if (dst_match) begin
                store_nxt[DST_AT]   = local_r[31:24];
                store_nxt[DST_AT+1] = local_r[23:16];
                store_nxt[DST_AT+2] = local_r[15:8];
                store_nxt[DST_AT+3] = local_r[7:0];
              end else if (src_match) begin
                store_nxt[SRC_AT]   = mapped_r[31:24];
                store_nxt[SRC_AT+1] = mapped_r[23:16];
                store_nxt[SRC_AT+2] = mapped_r[15:8];
                store_nxt[SRC_AT+3] = mapped_r[7:0];
              end
              if (dst_match || src_match) begin
                state_nxt = ST_SRC;
              end
              keep_nxt = (dst_match || src_match) && !in_packet_end_in;
              pos_nxt  = in_packet_end_in ? '0 : POS_BODY;
            end else begin
              pos_nxt = in_packet_end_in ? '0 : pos_r + POS_W'(1);
              if (in_packet_end_in) begin
                keep_nxt = 1'b0;
              end
            end
          end else begin
            q_push   = keep_r;
            pos_nxt  = in_packet_end_in ? '0 : POS_BODY;
            keep_nxt = keep_r && !in_packet_end_in;
          end
        end
      end
      ST_SRC: begin
        sum_nxt = sum_r + SUM_W'({store_r[SRC_AT], store_r[SRC_AT+1]})
                        + SUM_W'({store_r[SRC_AT+2], store_r[SRC_AT+3]});
        state_nxt = ST_DST;
      end
      ST_DST: begin
        sum_nxt = sum_r + SUM_W'({store_r[DST_AT], store_r[DST_AT+1]})
                        + SUM_W'({store_r[DST_AT+2], store_r[DST_AT+3]});
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          q_wdata   = '{kind: CMD_HDR, data: 8'h00, last: hend_r};
          csum_nxt  = ~fold2[15:0];
          lock_nxt  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_RUN;
      pos_r    <= '0;
      keep_r   <= 1'b0;
      lock_r   <= 1'b0;
      local_r  <= '0;
      mapped_r <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      keep_r  <= keep_nxt;
      lock_r  <= lock_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_LOCAL:  local_r  <= cfg_wdata;
          REG_MAPPED: mapped_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    store_r <= store_nxt;
    hend_r  <= hend_nxt;
    csum_r  <= csum_nxt;
  end

endmodule

@@ hw/rtl/ipv4arc_cmdq.sv @@
// Small command queue between the front end and the emitter.
module ipv4arc_cmdq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  ipv4arc_pkg::cmd_t wdata,
  output logic              q_full,
  input  logic              rd_en,
  output ipv4arc_pkg::cmd_t rdata,
  output logic              q_empty
);
  import ipv4arc_pkg::*;

  cmd_t                 mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic                 do_wr, do_rd;

  assign q_full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + Q_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - Q_CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ hw/rtl/ipv4arc_back.sv @@
// Emitter: plays out header bursts and body bytes into the result register.
module ipv4arc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  ipv4arc_pkg::cmd_t      q_head,
  output logic                   q_pop,
  input  ipv4arc_pkg::hdr_view_t hdr_view,
  output logic                   hdr_done,
  output logic                   empty,
  input  logic                   pop,
  output logic [7:0]             out_byte_out,
  output logic                   out_packet_end_out,
  output logic                   out_burst_last
);
  import ipv4arc_pkg::*;

  logic              valid_r, valid_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              end_r, end_nxt;
  logic              blast_r, blast_nxt;
  logic              act_r, act_nxt;
  logic [POS_W-1:0]  idx_r, idx_nxt;
  logic              hend_r, hend_nxt;
  logic              load;
  logic [7:0]        hdr_byte;

  assign load = !valid_r || pop;

  always_comb begin
    if (idx_r == POS_CSUM_HI) begin
      hdr_byte = hdr_view.csum[15:8];
    end else if (idx_r == POS_CSUM_LO) begin
      hdr_byte = hdr_view.csum[7:0];
    end else begin
      hdr_byte = hdr_view.bytes[idx_r];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    end_nxt   = end_r;
    blast_nxt = blast_r;
    act_nxt   = act_r;
    idx_nxt   = idx_r;
    hend_nxt  = hend_r;
    q_pop     = 1'b0;
    hdr_done  = 1'b0;
    if (load) begin
      valid_nxt = 1'b0;
      if (act_r) begin
        valid_nxt = 1'b1;
        byte_nxt  = hdr_byte;
        end_nxt   = (idx_r == POS_LAST) && hend_r;
        blast_nxt = (idx_r == POS_LAST);
        idx_nxt   = idx_r + POS_W'(1);
        if (idx_r == POS_LAST) begin
          act_nxt  = 1'b0;
          hdr_done = 1'b1;
        end
      end else if (!q_empty) begin
        q_pop     = 1'b1;
        valid_nxt = 1'b1;
        case (q_head.kind)
          CMD_HDR: begin
            byte_nxt  = hdr_view.bytes[0];
            end_nxt   = 1'b0;
            blast_nxt = 1'b0;
            act_nxt   = 1'b1;
            idx_nxt   = POS_W'(1);
            hend_nxt  = q_head.last;
          end
          default: begin
            byte_nxt  = q_head.data;
            end_nxt   = q_head.last;
            blast_nxt = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      act_r   <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      act_r   <= act_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    end_r   <= end_nxt;
    blast_r <= blast_nxt;
    hend_r  <= hend_nxt;
  end

  assign empty              = !valid_r;
  assign out_byte_out       = byte_r;
  assign out_packet_end_out = end_r;
  assign out_burst_last     = blast_r;

endmodule

@@ hw/rtl/ipv4_address_rewrite_checksum.sv @@
// Top level of the static NAT IPv4 header rewrite block.
// Bytes of an IPv4 packet enter one per transaction. The first 20 are held; on the 20th,
// a destination equal to mapped_address becomes local_address, else a source equal to
// local_address becomes mapped_address, else the packet is dropped along with any packet
// shorter than 20 bytes. A kept header gets a fresh checksum and leaves as a burst of 20
// results, then body bytes pass through one for one. Header bytes and body bytes are taken
// at one per cycle; after the 20th byte of a kept packet the front end finishes the
// checksum in ST_SRC, ST_DST and ST_PUSH, and the first header byte of the next packet
// waits until the 20-byte header burst has left the single header buffer. Body bytes go
// through a 4-entry command queue: up to four are taken while that burst drains, then the
// input stalls until the burst is out and the emitter takes body bytes again.
module ipv4_address_rewrite_checksum (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [ipv4arc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ipv4arc_pkg::ADDR_W-1:0]    cfg_wdata,
  input  logic                              push,
  output logic                              full,
  input  logic [7:0]                        in_byte_in,
  input  logic                              in_packet_end_in,
  output logic                              empty,
  input  logic                              pop,
  output logic [7:0]                        out_byte_out,
  output logic                              out_packet_end_out,
  output logic                              out_burst_last
);
  import ipv4arc_pkg::*;

  logic      q_push, q_full, q_pop, q_empty, hdr_done;
  cmd_t      q_wdata, q_head;
  hdr_view_t hdr_view;

  ipv4arc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .push             (push),
    .full             (full),
    .in_byte_in       (in_byte_in),
    .in_packet_end_in (in_packet_end_in),
    .q_push           (q_push),
    .q_wdata          (q_wdata),
    .q_full           (q_full),
    .hdr_done         (hdr_done),
    .hdr_view         (hdr_view)
  );

  ipv4arc_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wdata   (q_wdata),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rdata   (q_head),
    .q_empty (q_empty)
  );

  ipv4arc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .hdr_view           (hdr_view),
    .hdr_done           (hdr_done),
    .empty              (empty),
    .pop                (pop),
    .out_byte_out       (out_byte_out),
    .out_packet_end_out (out_packet_end_out),
    .out_burst_last     (out_burst_last)
  );

endmodule

@@ hw/rtl/ipv4arc_checker.sv @@
// Port-level checker for the rewrite block, bound to the top level.
`include "ipv4_address_rewrite_checksum_macros.svh"

module ipv4arc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_out,
  input logic       out_packet_end_out,
  input logic       out_burst_last
);

  `IARC_ASSERT(a_reset_idle, $rose(rst_n) |-> empty && !full, "not idle after reset")
  `IARC_ASSERT(a_end_closes_burst, !empty && out_packet_end_out |-> out_burst_last, "packet end inside burst")
  `IARC_ASSERT(a_result_stays, !empty && !pop |=> !empty, "result lost while stalled")
  `IARC_ASSERT_HOLD(a_result_holds, !empty && !pop, out_byte_out, "result byte changed while stalled")

endmodule

bind ipv4_address_rewrite_checksum ipv4arc_checker u_ipv4arc_checker (.*);

@@ tb/sv/ipv4_address_rewrite_checksum_tb.sv @@
// Self-checking testbench for the static NAT IPv4 header rewrite and checksum block.
`timescale 1ns / 100ps

module ipv4_address_rewrite_checksum_tb;
  import ipv4arc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       pkt_end;
    logic       burst_last;
  } nat_byte_t;

  typedef enum int {PKT_DST, PKT_SRC, PKT_BOTH, PKT_NEAR, PKT_MISS} pkt_kind_t;
  typedef enum int {FILL_RAND, FILL_ONES, FILL_ZERO} hdr_fill_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_wdata;
  logic                 push;
  logic                 full;
  logic [7:0]           in_byte_in;
  logic                 in_packet_end_in;
  logic                 empty;
  logic                 pop;
  logic [7:0]           out_byte_out;
  logic                 out_packet_end_out;
  logic                 out_burst_last;

  // predictor state
  logic [7:0]        hdr_buf [HDR_LEN];
  logic [POS_W-1:0]  hdr_count;
  logic              fwd_packet;
  logic [ADDR_W-1:0] nat_local;
  logic [ADDR_W-1:0] nat_mapped;
  nat_byte_t         rewritten_q [$];

  int errors      = 0;
  int cycles      = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold     = 0;

  ipv4_address_rewrite_checksum uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .push               (push),
    .full               (full),
    .in_byte_in         (in_byte_in),
    .in_packet_end_in   (in_packet_end_in),
    .empty              (empty),
    .pop                (pop),
    .out_byte_out       (out_byte_out),
    .out_packet_end_out (out_packet_end_out),
    .out_burst_last     (out_burst_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] header_checksum();
    logic [31:0] sum;
    sum = '0;
    for (int i = 0; i < HDR_LEN; i += 2)
      sum += {16'h0, hdr_buf[i], hdr_buf[i+1]};
    sum = (sum >> 16) + (sum & 32'hffff);
    sum = sum + (sum >> 16);
    return ~sum[15:0];
  endfunction

  task automatic predict_rewrite(input logic [7:0] b, input logic e);
    logic [31:0] dst;
    logic [31:0] src;
    logic [15:0] csum;
    if (hdr_count < POS_BODY) begin
      hdr_buf[hdr_count] = b;
      hdr_count++;
      if (hdr_count < POS_BODY) begin
        if (e) begin
          hdr_count = '0;
          fwd_packet = 1'b0;
        end
        return;
      end
      dst = {hdr_buf[DST_AT], hdr_buf[DST_AT+1], hdr_buf[DST_AT+2], hdr_buf[DST_AT+3]};
      src = {hdr_buf[SRC_AT], hdr_buf[SRC_AT+1], hdr_buf[SRC_AT+2], hdr_buf[SRC_AT+3]};
      fwd_packet = 1'b1;
      if (dst == nat_mapped) begin
        for (int k = 0; k < 4; k++) hdr_buf[DST_AT+k] = nat_local[31-8*k -: 8];
      end else if (src == nat_local) begin
        for (int k = 0; k < 4; k++) hdr_buf[SRC_AT+k] = nat_mapped[31-8*k -: 8];
      end else begin
        fwd_packet = 1'b0;
      end
      if (fwd_packet) begin
        hdr_buf[CSUM_AT]   = 8'h00;
        hdr_buf[CSUM_AT+1] = 8'h00;
        csum = header_checksum();
        hdr_buf[CSUM_AT]   = csum[15:8];
        hdr_buf[CSUM_AT+1] = csum[7:0];
        for (int i = 0; i < HDR_LEN; i++)
          rewritten_q.push_back('{hdr_buf[i], (i == HDR_LEN-1) && e, i == HDR_LEN-1});
      end
      if (e) begin
        hdr_count = '0;
        fwd_packet = 1'b0;
      end
      return;
    end
    if (fwd_packet) rewritten_q.push_back('{b, e, 1'b1});
    if (e) begin
      hdr_count = '0;
      fwd_packet = 1'b0;
    end else begin
      hdr_count = POS_BODY;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic e);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push             <= 1'b1;
    in_byte_in       <= b;
    in_packet_end_in <= e;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_rewrite(b, e);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (rewritten_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_nat_regs(input logic [31:0] lo, input logic [31:0] mp);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_LOCAL;
    cfg_wdata <= lo;
    @(posedge clk);
    nat_local = lo;
    cfg_index <= REG_MAPPED;
    cfg_wdata <= mp;
    @(posedge clk);
    nat_mapped = mp;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_packet(input pkt_kind_t kind, input int len, input hdr_fill_t fill);
    logic [7:0]  pk [HDR_LEN];
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] flip;
    for (int i = 0; i < HDR_LEN; i++)
      pk[i] = (fill == FILL_ONES) ? 8'hff : (fill == FILL_ZERO) ? 8'h00 : 8'($urandom_range(255));
    src  = {pk[SRC_AT], pk[SRC_AT+1], pk[SRC_AT+2], pk[SRC_AT+3]};
    dst  = {pk[DST_AT], pk[DST_AT+1], pk[DST_AT+2], pk[DST_AT+3]};
    flip = $urandom | (32'h1 << $urandom_range(31));
    case (kind)
      PKT_DST: dst = nat_mapped;
      PKT_SRC: begin
        src = nat_local;
        dst = nat_mapped ^ flip;
      end
      PKT_BOTH: begin
        src = nat_local;
        dst = nat_mapped;
      end
      PKT_NEAR: begin
        src = nat_local ^ (32'h1 << $urandom_range(31));
        dst = nat_mapped ^ (32'h1 << $urandom_range(31));
      end
      default: begin
        src = nat_local ^ ($urandom | (32'h1 << $urandom_range(31)));
        dst = nat_mapped ^ flip;
      end
    endcase
    for (int k = 0; k < 4; k++) begin
      pk[SRC_AT+k] = src[31-8*k -: 8];
      pk[DST_AT+k] = dst[31-8*k -: 8];
    end
    for (int i = 0; i < len; i++)
      send_byte((i < HDR_LEN) ? pk[i] : 8'($urandom_range(255)), i == len-1);
  endtask

  // both registers at reset value zero
  task automatic test_reset_registers();
    tx_idle_pct = 10;
    rx_idle_pct = 30;
    send_packet(PKT_DST, 21, FILL_ZERO);
    send_packet(PKT_SRC, 20, FILL_ONES);
  endtask

  task automatic test_exact_header();
    write_nat_regs(32'hffffffff, 32'h00000000);
    send_packet(PKT_DST, HDR_LEN, FILL_ONES);
    send_packet(PKT_SRC, HDR_LEN, FILL_RAND);
  endtask

  task automatic test_address_match();
    write_nat_regs(32'h00000000, 32'hffffffff);
    // destination match takes priority over source match
    send_packet(PKT_BOTH, 21, FILL_RAND);
  endtask

  task automatic test_dropped_packets();
    write_nat_regs($urandom, $urandom);
    send_packet(PKT_MISS, 20, FILL_RAND);
    send_packet(PKT_NEAR, 20, FILL_ONES);
    send_packet(PKT_DST, 19, FILL_RAND);
    send_packet(PKT_DST, 1, FILL_RAND);
  endtask

  // registers take effect when the last header byte arrives
  task automatic test_midpacket_config();
    logic [7:0]  pk [HDR_LEN];
    logic [31:0] lo;
    logic [31:0] mp;
    lo = $urandom;
    mp = $urandom;
    for (int i = 0; i < HDR_LEN; i++) pk[i] = 8'($urandom_range(255));
    for (int k = 0; k < 4; k++) pk[DST_AT+k] = mp[31-8*k -: 8];
    for (int i = 0; i < 6; i++) send_byte(pk[i], 1'b0);
    write_nat_regs(lo, mp);
    for (int i = 6; i < HDR_LEN; i++) send_byte(pk[i], 1'b0);
    send_byte(8'h5a, 1'b1);
  endtask

  task automatic test_backpressure();
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold = 400;
    send_packet(PKT_DST, 30, FILL_RAND);
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_bytes);
    int        sent;
    int        len;
    int        r;
    pkt_kind_t kind;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_bytes) begin
      r = $urandom_range(99);
      kind = pkt_kind_t'((r < 35) ? PKT_DST : (r < 60) ? PKT_SRC : (r < 70) ? PKT_BOTH :
                         (r < 85) ? PKT_NEAR : PKT_MISS);
      r = $urandom_range(99);
      len = (r < 10) ? $urandom_range(1, HDR_LEN-1) : (r < 25) ? HDR_LEN :
            (r < 95) ? $urandom_range(HDR_LEN+1, 40) : $urandom_range(41, 64);
      send_packet(kind, len, FILL_RAND);
      sent += len;
    end
  endtask

  // result side: pop pacing and per-transaction check
  initial begin
    nat_byte_t want;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (rewritten_q.size() == 0) begin
          $display("%0t: unexpected result: byte %h end %b last %b", $time,
                   out_byte_out, out_packet_end_out, out_burst_last);
          errors++;
        end else begin
          want = rewritten_q.pop_front();
          if (out_byte_out !== want.data) begin
            $display("%0t: byte_out expected %h actual %h", $time, want.data, out_byte_out);
            errors++;
          end
          if (out_packet_end_out !== want.pkt_end) begin
            $display("%0t: packet_end_out expected %b actual %b", $time,
                     want.pkt_end, out_packet_end_out);
            errors++;
          end
          if (out_burst_last !== want.burst_last) begin
            $display("%0t: burst_last expected %b actual %b", $time,
                     want.burst_last, out_burst_last);
            errors++;
          end
        end
      end
      if (!rst_n) begin
        pop <= 1'b0;
      end else if (rx_hold > 0) begin
        pop <= 1'b0;
        rx_hold--;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("ipv4_address_rewrite_checksum_tb NOT OK");
    $finish;
  end

  initial begin
    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_index        <= REG_LOCAL;
    cfg_wdata        <= '0;
    push             <= 1'b0;
    in_byte_in       <= '0;
    in_packet_end_in <= 1'b0;
    for (int i = 0; i < HDR_LEN; i++) hdr_buf[i] = '0;
    hdr_count  = '0;
    fwd_packet = 1'b0;
    nat_local  = '0;
    nat_mapped = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_registers();
    test_exact_header();
    test_address_match();
    test_dropped_packets();
    test_midpacket_config();
    test_backpressure();
    write_nat_regs(32'h00000000, 32'hffffffff);
    test_random_traffic(27, 86, 15);
    write_nat_regs(32'hffffffff, 32'h00000000);
    test_random_traffic(86, 27, 15);
    write_nat_regs($urandom, $urandom);
    test_random_traffic(0, 0, 15);
    wait_drained();

    if (errors == 0)
      $display("ipv4_address_rewrite_checksum_tb OK");
    else
      $display("ipv4_address_rewrite_checksum_tb NOT OK");
    $finish;
  end

endmodule
